>>> hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also active while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/edfs_pkg.sv
// Types, codes and the quality rate table of the EDF scheduler.
package edfs_pkg;

  localparam int USER_W = 6;   // up to 64 users
  localparam int SLOT_W = 10;  // up to 1024 slots per queue
  localparam int FILL_W = 11;

  localparam logic [1:0] KIND_ENQ   = 2'd0;
  localparam logic [1:0] KIND_CHAN  = 2'd1;
  localparam logic [1:0] KIND_SCHED = 2'd2;

  localparam logic [1:0] RES_DONE = 2'd0;
  localparam logic [1:0] RES_SUM  = 2'd1;
  localparam logic [1:0] RES_REJ  = 2'd2;

  localparam logic REG_USER_COUNT = 1'b0;
  localparam logic REG_COMP_CAP   = 1'b1;

  localparam logic [2:0] CELL_NOP  = 3'd0;
  localparam logic [2:0] CELL_PUSH = 3'd1;
  localparam logic [2:0] CELL_CHAN = 3'd2;
  localparam logic [2:0] CELL_POP  = 3'd3;
  localparam logic [2:0] CELL_LOAD = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [USER_W-1:0] user;
    logic [31:0]       dl;
    logic [11:0]       rate;
    logic [3:0]        quality;
  } cell_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [USER_W-1:0] user;
    logic [31:0]       dl;
    logic [SLOT_W-1:0] head;
    logic [FILL_W-1:0] fill;
    logic [11:0]       rate;
    logic [3:0]        quality;
  } cand_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [FILL_W-1:0] fill;
  } cell_stat_t;

  typedef struct packed {
    logic [31:0] arrival;
    logic [31:0] deadline;
    logic [19:0] remaining;
  } pkt_t;

  function automatic logic [11:0] rate_lookup(input logic [3:0] q);
    logic [11:0] r;
    case (q)
      4'd0, 4'd1: r = 12'd48;
      4'd2:  r = 12'd72;
      4'd3:  r = 12'd96;
      4'd4:  r = 12'd120;
      4'd5:  r = 12'd144;
      4'd6:  r = 12'd192;
      4'd7:  r = 12'd240;
      4'd8:  r = 12'd288;
      4'd9:  r = 12'd336;
      4'd10: r = 12'd408;
      4'd11: r = 12'd480;
      4'd12: r = 12'd552;
      4'd13: r = 12'd648;
      4'd14: r = 12'd744;
      default: r = 12'd840;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/edfs_item_if.sv
// Input item channel of the scheduler.
interface edfs_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  user;
  logic [31:0] arrival_time;
  logic [31:0] deadline_time;
  logic [19:0] packet_size;
  logic [11:0] rate_per_block;
  logic [3:0]  quality;
  logic [8:0]  block_budget;

  modport source(output valid, kind, user, arrival_time, deadline_time, packet_size,
                 rate_per_block, quality, block_budget, input ready);
  modport sink(input valid, kind, user, arrival_time, deadline_time, packet_size,
               rate_per_block, quality, block_budget, output ready);
endinterface

>>> hdl/edfs_result_if.sv
// Result item channel of the scheduler.
interface edfs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  done_user;
  logic [31:0] done_arrival;
  logic [31:0] done_deadline;
  logic [19:0] done_size;
  logic [8:0]  final_blocks;
  logic [3:0]  quality_at_send;
  logic [20:0] bits_sent;
  logic [8:0]  blocks_used;
  logic        last;

  modport source(output valid, result_kind, done_user, done_arrival, done_deadline,
                 done_size, final_blocks, quality_at_send, bits_sent, blocks_used, last,
                 input ready);
  modport sink(input valid, result_kind, done_user, done_arrival, done_deadline,
               done_size, final_blocks, quality_at_send, bits_sent, blocks_used, last,
               output ready);
endinterface

>>> hdl/edf_resource_block_scheduler.sv
// Earliest-deadline-first resource block scheduler. Enqueue and channel-update items are
// applied before the next item is taken; a rejected enqueue also hands over its result. A
// schedule item runs passes: the user cells hand the best candidate down the row one cell per
// cycle, the packet memory is read, the serial divider computes ceil(bits/rate), and then come
// allocation, update, record, pop and the refresh of the next head deadline; every result waits
// for the output register to be free. Packets live in a single-port-write packet memory of
// NUM_USERS*QUEUE_DEPTH entries that needs no clearing after reset.
`include "assert_macros.svh"
module edf_resource_block_scheduler import edfs_pkg::*; #(
  parameter int NUM_USERS   = 16,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  edfs_item_if.sink     item_in,
  edfs_result_if.source result_out,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [5:0]    cfg_data
);

  localparam int DEPTH = NUM_USERS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(NUM_USERS + 1);
  localparam logic [AW-1:0] QD_A = AW'(QUEUE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ENQ   = 4'd1;
  localparam logic [3:0] S_REJ   = 4'd2;
  localparam logic [3:0] S_CHAN  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_DIVST = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_ALLOC = 4'd8;
  localparam logic [3:0] S_APPLY = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;
  localparam logic [3:0] S_REC   = 4'd11;
  localparam logic [3:0] S_POP   = 4'd12;
  localparam logic [3:0] S_LOAD  = 4'd13;
  localparam logic [3:0] S_SUM   = 4'd14;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [4:0]  user_count;
  logic [5:0]  comp_cap;

  // latched item
  logic [3:0]  usr;
  logic [31:0] arr;
  logic [31:0] dl;
  logic [19:0] size;
  logic [11:0] new_rate;
  logic [3:0]  new_q;

  // interval state
  logic [8:0]  budget;
  logic [8:0]  used;
  logic [20:0] bits_total;
  logic [5:0]  recs;
  logic [CW-1:0] scan_cnt;
  cand_t       pick;
  pkt_t        cur;
  logic [8:0]  alloc;
  logic [20:0] sent;
  logic        complete;

  cell_cmd_t   cmd;
  cand_t       chain [0:NUM_USERS];
  cell_stat_t  stat [0:NUM_USERS-1];
  cell_stat_t  sel;
  logic        usr_ok;
  logic        full;
  logic [11:0] enq_sum;
  logic [11:0] enq_slot;
  logic [SLOT_W-1:0] new_head;

  pkt_t        mem [0:DEPTH-1];
  pkt_t        rdata;
  logic        mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  pkt_t        wdata;

  logic        div_start;
  logic        div_done;
  logic [20:0] quot;
  logic [20:0] need;
  logic [20:0] sent_w;

  logic        accept;
  logic        out_free;
  logic        emit;

  assign item_in.ready = (state == S_IDLE);
  assign accept        = item_in.valid && item_in.ready;
  assign out_free      = !result_out.valid || result_out.ready;
  assign usr_ok        = ({3'b000, item_in.user} < 7'(NUM_USERS));

  // cell row
  assign chain[0] = '0;
  for (genvar i = 0; i < NUM_USERS; i++) begin : g_cell
    edfs_cell #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (USER_W'(i)),
      .en       (7'(i) < {2'b00, user_count}),
      .cmd      (cmd),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1]),
      .stat     (stat[i])
    );
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_USERS; i++) begin
      if (USER_W'(i) == USER_W'(usr)) sel = stat[i];
    end
  end

  assign full     = (sel.fill >= FILL_W'(QUEUE_DEPTH));
  assign enq_sum  = 12'(sel.head) + 12'(sel.fill);
  assign enq_slot = (enq_sum >= 12'(QUEUE_DEPTH)) ? enq_sum - 12'(QUEUE_DEPTH) : enq_sum;
  assign new_head = (pick.head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : pick.head + 1'b1;

  always_comb begin
    cmd = '{op: CELL_NOP, user: USER_W'(usr), dl: dl, rate: new_rate, quality: new_q};
    unique case (state)
      S_ENQ:   if (!full) cmd.op = CELL_PUSH;
      S_CHAN:  cmd.op = CELL_CHAN;
      S_POP:   begin
        cmd.op   = CELL_POP;
        cmd.user = pick.user;
      end
      S_LOAD:  begin
        cmd.op   = CELL_LOAD;
        cmd.user = pick.user;
        cmd.dl   = rdata.deadline;
      end
      default: ;
    endcase
  end

  // packet memory
  always_comb begin
    mem_we = 1'b0;
    waddr  = AW'(usr) * QD_A + AW'(enq_slot);
    wdata  = '{arrival: arr, deadline: dl, remaining: size};
    if (state == S_ENQ && !full) begin
      mem_we = 1'b1;
    end else if (state == S_UPD && !complete) begin
      mem_we = 1'b1;
      waddr  = AW'(pick.user) * QD_A + AW'(pick.head);
      wdata  = '{arrival: cur.arrival, deadline: cur.deadline,
                 remaining: cur.remaining - sent[19:0]};
    end
  end

  assign raddr = (state == S_POP) ? AW'(pick.user) * QD_A + AW'(new_head)
                                  : AW'(pick.user) * QD_A + AW'(pick.head);

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // divide stage
  assign div_start = (state == S_DIVST);
  edfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({1'b0, rdata.remaining} + 21'(pick.rate) - 21'd1),
    .den   (pick.rate),
    .done  (div_done),
    .quot  (quot)
  );

  assign need   = (quot == '0) ? 21'd1 : quot;
  assign sent_w = 21'(alloc) * 21'(pick.rate);

  // state machine
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: if (accept) begin
        case (item_in.kind)
          KIND_ENQ:   state_next = usr_ok ? S_ENQ : S_IDLE;
          KIND_CHAN:  state_next = usr_ok ? S_CHAN : S_IDLE;
          KIND_SCHED: state_next = S_SCAN;
          default:    state_next = S_IDLE;
        endcase
      end
      S_ENQ:   state_next = full ? S_REJ : S_IDLE;
      S_REJ:   if (out_free) begin
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      S_CHAN:  state_next = S_IDLE;
      S_SCAN: begin
        if (budget == '0) state_next = S_SUM;
        else if (scan_cnt == CW'(NUM_USERS))
          state_next = chain[NUM_USERS].valid ? S_RD : S_SUM;
      end
      S_RD:    state_next = S_DIVST;
      S_DIVST: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_ALLOC;
      S_ALLOC: state_next = S_APPLY;
      S_APPLY: state_next = S_UPD;
      S_UPD: begin
        if (!complete)            state_next = S_SCAN;
        else if (recs < comp_cap) state_next = S_REC;
        else                      state_next = S_POP;
      end
      S_REC:   if (out_free) begin
        emit       = 1'b1;
        state_next = S_POP;
      end
      S_POP:   state_next = (pick.fill > FILL_W'(1)) ? S_LOAD : S_SCAN;
      S_LOAD:  state_next = S_SCAN;
      S_SUM:   if (out_free) begin
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      user_count <= 5'd16;
      comp_cap   <= 6'd63;
      scan_cnt   <= '0;
    end else begin
      state    <= state_next;
      scan_cnt <= (state == S_SCAN) ? scan_cnt + 1'b1 : '0;
      if (cfg_we) begin
        case (cfg_index)
          REG_USER_COUNT: user_count <= cfg_data[4:0];
          default:        comp_cap   <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      usr        <= item_in.user;
      arr        <= item_in.arrival_time;
      dl         <= item_in.deadline_time;
      size       <= item_in.packet_size;
      new_rate   <= item_in.rate_per_block;
      new_q      <= item_in.quality;
      budget     <= item_in.block_budget;
      used       <= '0;
      bits_total <= '0;
      recs       <= '0;
    end
    if (state == S_SCAN) pick <= chain[NUM_USERS];
    if (state == S_DIVST) cur <= rdata;
    if (state == S_ALLOC) alloc <= (need <= {12'd0, budget}) ? need[8:0] : budget;
    if (state == S_APPLY) begin
      sent     <= sent_w;
      complete <= ({1'b0, cur.remaining} <= sent_w);
    end
    if (state == S_UPD) begin
      budget     <= budget - alloc;
      used       <= used + alloc;
      bits_total <= bits_total + sent;
    end
    if (state == S_REC && out_free) recs <= recs + 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (emit) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_out.result_kind     <= RES_SUM;
      result_out.done_user       <= '0;
      result_out.done_arrival    <= '0;
      result_out.done_deadline   <= '0;
      result_out.done_size       <= '0;
      result_out.final_blocks    <= '0;
      result_out.quality_at_send <= '0;
      result_out.bits_sent       <= '0;
      result_out.blocks_used     <= '0;
      result_out.last            <= 1'b1;
      case (state)
        S_REJ: begin
          result_out.result_kind   <= RES_REJ;
          result_out.done_user     <= usr;
          result_out.done_arrival  <= arr;
          result_out.done_deadline <= dl;
          result_out.done_size     <= size;
        end
        S_REC: begin
          result_out.result_kind     <= RES_DONE;
          result_out.done_user       <= pick.user[3:0];
          result_out.done_arrival    <= cur.arrival;
          result_out.done_deadline   <= cur.deadline;
          result_out.done_size       <= cur.remaining;
          result_out.final_blocks    <= alloc;
          result_out.quality_at_send <= pick.quality;
          result_out.last            <= 1'b0;
        end
        default: begin
          result_out.bits_sent   <= bits_total;
          result_out.blocks_used <= used;
        end
      endcase
    end
  end

  `ASSERT_HOLDS(a_alloc_in_budget, (state == S_UPD) |-> (alloc != '0 && alloc <= budget), "allocation outside budget")
  `ASSERT_HOLDS(a_pick_nonempty, (state == S_DIVST) |-> (pick.valid && pick.fill != '0), "served an empty queue")
  `ASSERT_HOLDS(a_out_hold, (result_out.valid && !result_out.ready) |=> result_out.valid, "result dropped while stalled")

endmodule

>>> hdl/edfs_cell.sv
// One user cell: queue head/fill, channel values, cached head deadline, pick stage.
`include "assert_macros.svh"
module edfs_cell import edfs_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [USER_W-1:0] idx,
  input  logic              en,
  input  cell_cmd_t         cmd,
  input  cand_t             cand_in,
  output cand_t             cand_out,
  output cell_stat_t        stat
);

  logic [SLOT_W-1:0] head;
  logic [FILL_W-1:0] fill;
  logic [11:0]       rate;
  logic [3:0]        quality;
  logic [31:0]       hd_dl;
  logic              hit;
  logic [11:0]       eff_rate;
  logic              take;

  assign hit      = (cmd.user == idx);
  assign eff_rate = (rate != 12'd0) ? rate : rate_lookup(quality);
  // strict compare: an earlier (lower) user keeps a tie
  assign take     = en && (fill != '0) && (!cand_in.valid || (hd_dl < cand_in.dl));

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      fill    <= '0;
      rate    <= '0;
      quality <= '0;
    end else if (hit) begin
      unique case (cmd.op)
        CELL_PUSH: fill <= fill + 1'b1;
        CELL_CHAN: begin
          rate    <= cmd.rate;
          quality <= cmd.quality;
        end
        CELL_POP: begin
          head <= (head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
          fill <= fill - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hit && (((cmd.op == CELL_PUSH) && (fill == '0)) || (cmd.op == CELL_LOAD))) begin
      hd_dl <= cmd.dl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
    end else if (take) begin
      cand_out <= '{valid: 1'b1, user: idx, dl: hd_dl, head: head, fill: fill,
                    rate: eff_rate, quality: quality};
    end else begin
      cand_out <= cand_in;
    end
  end

  assign stat = '{head: head, fill: fill};

  `ASSERT_HOLDS(a_fill_bound, fill <= FILL_W'(QUEUE_DEPTH), "queue fill beyond depth")
  `ASSERT_HOLDS(a_pop_nonempty, (hit && cmd.op == CELL_POP) |-> (fill != '0), "pop of empty queue")
  `ASSERT_HOLDS(a_push_room, (hit && cmd.op == CELL_PUSH) |-> (fill < FILL_W'(QUEUE_DEPTH)), "push into full queue")

endmodule

>>> hdl/edfs_div.sv
// Restoring divider, one quotient bit per cycle.
module edfs_div import edfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [20:0] num,
  input  logic [11:0] den,
  output logic        done,
  output logic [20:0] quot
);

  logic        run;
  logic [4:0]  cnt;
  logic [11:0] r;
  logic [11:0] d;
  logic [12:0] trial;

  assign trial = {r, quot[20]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd21;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      r    <= '0;
      d    <= den;
    end else if (run) begin
      if (trial >= {1'b0, d}) begin
        r    <= 12'(trial - {1'b0, d});
        quot <= {quot[19:0], 1'b1};
      end else begin
        r    <= trial[11:0];
        quot <= {quot[19:0], 1'b0};
      end
    end
  end

endmodule
